// ===== src/bgr_pkg.sv =====
// Shared types, coefficients and helpers for the BGR to 4:2:0 YCbCr converter.
// Used by every module under src; depends on nothing else.

package bgr_pkg;

   // Default size limits and register reset values.
   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;
   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // Register indexes on the configuration port.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Q16 coefficients; the chroma ones are magnitudes, signs are applied in the sums.
   localparam logic [16:0] Y_R  = 17'd19595;
   localparam logic [16:0] Y_G  = 17'd38470;
   localparam logic [16:0] Y_B  = 17'd7471;
   localparam logic [14:0] CB_R = 15'd11076;
   localparam logic [14:0] CB_G = 15'd21692;
   localparam logic [14:0] CR_G = 15'd27460;
   localparam logic [14:0] CR_B = 15'd5308;

   // Rounding constants: luma adds one half at bit 16, chroma adds the 128
   // offset and one half at bit 18 (four-pixel sums carry two more bits).
   localparam logic [24:0] LUMA_HALF   = 25'd32768;
   localparam logic [27:0] CHROMA_BIAS = 28'd33685504;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_type;

   typedef struct packed {
      logic        is_chroma;
      logic [7:0]  luma;
      logic [7:0]  cb;
      logic [7:0]  cr;
      logic [11:0] column;
      logic [11:0] row;
      logic        last;
   } rsp_type;

   // One classified pixel on its way from the front to the back.
   typedef struct packed {
      logic        is_chroma;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [11:0] luma_column;
      logic [11:0] luma_row;
      logic [11:0] chroma_column;
      logic [11:0] chroma_row;
      logic [9:0]  sum_blue;
      logic [9:0]  sum_green;
      logic [9:0]  sum_red;
   } job_type;

   // Force a size register even and into the range 2..limit.
   function automatic logic [12:0] eff_size(input logic [12:0] value,
                                            input logic [13:0] limit);
      logic [12:0] v;
      v = {value[12:1], 1'b0};
      if (v < 13'd2) v = 13'd2;
      if ({1'b0, v} > limit) v = {limit[12:1], 1'b0};
      return v;
   endfunction

   // Clamp a chroma accumulator (bias already added) to 0..255.
   function automatic logic [7:0] clamp_chroma(input logic [27:0] acc);
      logic [7:0] res;
      if (acc[27]) res = 8'd0;
      else if (acc[26:18] > 9'd255) res = 8'd255;
      else res = acc[25:18];
      return res;
   endfunction

endpackage

// ===== src/bgr_queue.sv =====
// Short job queue that decouples the pixel front from the arithmetic back.
// Depends on bgr_pkg for the job type and the queue depth.

module bgr_queue import bgr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  job_type             push_job,
   input  logic                pop,
   output logic                head_valid,
   output job_type             head_job,
   output logic [QUEUE_CW-1:0] count
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_CW-1:0] count_ff;
   logic [QUEUE_CW-1:0] count_in;
   logic                do_pop;

   // The front only pushes when a slot is free, so no full check here.
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) count_in = count_ff + QUEUE_CW'(1);
      else if (!push_valid && do_pop) count_in = count_ff - QUEUE_CW'(1);
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         count_ff <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_job;
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== src/bgr_front.sv =====
// Front end: accepts pixels, tracks position, pairs pixels and keeps the line
// store of even-row pair sums. Depends on bgr_pkg.

module bgr_front import bgr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [12:0]         csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   input  logic [QUEUE_CW-1:0] queue_count,
   output logic                push_valid,
   output job_type             push_job
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [13:0] WIDTH_LIMIT  = 14'(MAX_WIDTH);
   localparam logic [13:0] HEIGHT_LIMIT = 14'(MAX_HEIGHT);

   logic [12:0]  width_ff;
   logic [12:0]  height_ff;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   req_type      held_ff;
   logic [26:0]  line_mem [LINE_DEPTH];
   logic [26:0]  line_rd_ff;

   logic         s1_valid_ff;
   logic         s1_chroma_ff;
   req_type      s1_pixel_ff;
   logic [8:0]   s1_sum_b_ff;
   logic [8:0]   s1_sum_g_ff;
   logic [8:0]   s1_sum_r_ff;
   logic [11:0]  s1_lcol_ff;
   logic [11:0]  s1_lrow_ff;
   logic [11:0]  s1_ccol_ff;
   logic [11:0]  s1_crow_ff;

   logic         req_fire;
   logic [QUEUE_CW:0] occupancy;
   logic [CW:0]  col_inc;
   logic [RW:0]  row_inc;
   logic [CW-1:0] col_half;
   logic [AW-1:0] line_idx;
   logic [8:0]   pair_b;
   logic [8:0]   pair_g;
   logic [8:0]   pair_r;
   logic         odd_col;
   logic         odd_row;

   // Room is counted for the word already in the pairing stage.
   assign occupancy = {1'b0, queue_count} + {{QUEUE_CW{1'b0}}, s1_valid_ff};
   assign req_ready = occupancy < (QUEUE_CW + 1)'(QUEUE_DEPTH);
   assign req_fire  = req_valid && req_ready;

   assign odd_col  = col_ff[0];
   assign odd_row  = row_ff[0];
   assign col_half = col_ff >> 1;
   assign line_idx = AW'(col_half);
   assign pair_b   = {1'b0, req_data.blue}  + {1'b0, held_ff.blue};
   assign pair_g   = {1'b0, req_data.green} + {1'b0, held_ff.green};
   assign pair_r   = {1'b0, req_data.red}   + {1'b0, held_ff.red};

   // Raster position: the column wraps at the width, the row at the height.
   always_comb begin
      col_inc = {1'b0, col_ff} + (CW + 1)'(1);
      row_inc = {1'b0, row_ff} + (RW + 1)'(1);
      col_in  = col_inc[CW-1:0];
      row_in  = row_ff;
      if (14'(col_inc) >= {1'b0, width_ff}) begin
         col_in = '0;
         row_in = row_inc[RW-1:0];
         if (14'(row_inc) >= {1'b0, height_ff}) row_in = '0;
      end
   end

   // Configuration, counters, held pixel and the pairing stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= eff_size(WIDTH_RESET, WIDTH_LIMIT);
         height_ff   <= eff_size(HEIGHT_RESET, HEIGHT_LIMIT);
         col_ff      <= '0;
         row_ff      <= '0;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= eff_size(csr_data, WIDTH_LIMIT);
               CSR_FRAME_HEIGHT: height_ff <= eff_size(csr_data, HEIGHT_LIMIT);
               default: ;
            endcase
         end
         if (req_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (!odd_col) held_ff <= req_data;
         end
         s1_valid_ff <= req_fire;
      end
   end

   // Pairing stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_chroma_ff <= odd_col && odd_row;
         s1_pixel_ff  <= req_data;
         s1_sum_b_ff  <= pair_b;
         s1_sum_g_ff  <= pair_g;
         s1_sum_r_ff  <= pair_r;
         s1_lcol_ff   <= 12'(col_ff);
         s1_lrow_ff   <= 12'(row_ff);
         s1_ccol_ff   <= 12'(col_ff >> 1);
         s1_crow_ff   <= 12'(row_ff >> 1);
      end
   end

   // Line store: even rows write pair sums, odd rows read them back.
   always_ff @(posedge clock) begin
      if (req_fire && odd_col && !odd_row) line_mem[line_idx] <= {pair_r, pair_g, pair_b};
      if (req_fire && odd_col && odd_row) line_rd_ff <= line_mem[line_idx];
   end

   // Combine the two pair sums into the four-pixel sums and hand the word on.
   always_comb begin
      push_job.is_chroma     = s1_chroma_ff;
      push_job.blue          = s1_pixel_ff.blue;
      push_job.green         = s1_pixel_ff.green;
      push_job.red           = s1_pixel_ff.red;
      push_job.luma_column   = s1_lcol_ff;
      push_job.luma_row      = s1_lrow_ff;
      push_job.chroma_column = s1_ccol_ff;
      push_job.chroma_row    = s1_crow_ff;
      push_job.sum_blue      = {1'b0, s1_sum_b_ff} + {1'b0, line_rd_ff[8:0]};
      push_job.sum_green     = {1'b0, s1_sum_g_ff} + {1'b0, line_rd_ff[17:9]};
      push_job.sum_red       = {1'b0, s1_sum_r_ff} + {1'b0, line_rd_ff[26:18]};
   end

   assign push_valid = s1_valid_ff;

endmodule

// ===== src/bgr_back.sv =====
// Back end: products, sums with rounding and clamping, and the result register
// that emits luma and then chroma. Depends on bgr_pkg.

module bgr_back import bgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Product stage.
   logic        p_valid_ff;
   job_type     p_job_ff;
   logic [23:0] py_r_ff;
   logic [23:0] py_g_ff;
   logic [23:0] py_b_ff;
   logic [24:0] pcb_r_ff;
   logic [24:0] pcb_g_ff;
   logic [24:0] pcr_g_ff;
   logic [24:0] pcr_b_ff;

   // Sum stage.
   logic        s_valid_ff;
   job_type     s_job_ff;
   logic [7:0]  s_luma_ff;
   logic [7:0]  s_cb_ff;
   logic [7:0]  s_cr_ff;

   // Result register.
   logic        out_valid_ff;
   logic        out_phase_ff;
   job_type     out_job_ff;
   logic [7:0]  out_luma_ff;
   logic [7:0]  out_cb_ff;
   logic [7:0]  out_cr_ff;

   logic        advance;
   logic        rsp_fire;
   logic        out_done;
   logic [24:0] y_sum;
   logic [27:0] cb_acc;
   logic [27:0] cr_acc;

   assign rsp_fire = out_valid_ff && rsp_ready;
   assign out_done = out_phase_ff || !out_job_ff.is_chroma;
   // The whole pipeline moves when the result register is free this cycle.
   assign advance  = !out_valid_ff || (rsp_fire && out_done);
   assign pop      = advance && head_valid;

   // Weighted sums of the product stage with rounding.
   assign y_sum  = {1'b0, py_r_ff} + {1'b0, py_g_ff} + {1'b0, py_b_ff} + LUMA_HALF;
   assign cb_acc = 28'({p_job_ff.sum_blue, 15'd0}) - 28'(pcb_r_ff) - 28'(pcb_g_ff)
                   + CHROMA_BIAS;
   assign cr_acc = 28'({p_job_ff.sum_red, 15'd0}) - 28'(pcr_g_ff) - 28'(pcr_b_ff)
                   + CHROMA_BIAS;

   // Valid bits and output phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
      end else begin
         if (advance) begin
            p_valid_ff   <= head_valid;
            s_valid_ff   <= p_valid_ff;
            out_valid_ff <= s_valid_ff;
            out_phase_ff <= 1'b0;
         end else if (rsp_fire) begin
            out_phase_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         p_job_ff <= head_job;
         py_r_ff  <= 24'(Y_R * 24'(head_job.red));
         py_g_ff  <= 24'(Y_G * 24'(head_job.green));
         py_b_ff  <= 24'(Y_B * 24'(head_job.blue));
         pcb_r_ff <= 25'(CB_R * 25'(head_job.sum_red));
         pcb_g_ff <= 25'(CB_G * 25'(head_job.sum_green));
         pcr_g_ff <= 25'(CR_G * 25'(head_job.sum_green));
         pcr_b_ff <= 25'(CR_B * 25'(head_job.sum_blue));

         s_job_ff  <= p_job_ff;
         s_luma_ff <= (y_sum[24:16] > 9'd255) ? 8'd255 : y_sum[23:16];
         s_cb_ff   <= clamp_chroma(cb_acc);
         s_cr_ff   <= clamp_chroma(cr_acc);

         out_job_ff  <= s_job_ff;
         out_luma_ff <= s_luma_ff;
         out_cb_ff   <= s_cb_ff;
         out_cr_ff   <= s_cr_ff;
      end
   end

   // First the luma word, then for a chroma pixel the chroma word.
   always_comb begin
      if (out_phase_ff) begin
         rsp_data.is_chroma = 1'b1;
         rsp_data.luma      = 8'd0;
         rsp_data.cb        = out_cb_ff;
         rsp_data.cr        = out_cr_ff;
         rsp_data.column    = out_job_ff.chroma_column;
         rsp_data.row       = out_job_ff.chroma_row;
         rsp_data.last      = 1'b1;
      end else begin
         rsp_data.is_chroma = 1'b0;
         rsp_data.luma      = out_luma_ff;
         rsp_data.cb        = 8'd0;
         rsp_data.cr        = 8'd0;
         rsp_data.column    = out_job_ff.luma_column;
         rsp_data.row       = out_job_ff.luma_row;
         rsp_data.last      = !out_job_ff.is_chroma;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== src/bgr_to_nv12_converter.sv =====
// BGR to full-range BT.601 YCbCr 4:2:0 converter, luma and chroma words interleaved.
// A luma word is offered after the pairing register, the queue entry and the product,
// sum and result registers. Throughput: one pixel per cycle when neither side stalls; the
// result port moves one word per cycle, so a chroma pixel holds it for two words.
// Reset (synchronous): counters, held pixel and valids clear, size 640x480;
// the line store is not cleared and is written by every even row before use.

module bgr_to_nv12_converter import bgr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic                push_valid;
   job_type             push_job;
   logic                pop;
   logic                head_valid;
   job_type             head_job;
   logic [QUEUE_CW-1:0] queue_count;

   // Pixel intake, pairing and line store.
   bgr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // Decoupling queue.
   bgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (queue_count)
   );

   // Color arithmetic and result words.
   bgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== dv/tb_bgr_to_nv12_converter.sv =====
// Self-checking testbench for bgr_to_nv12_converter: random pixel streams and frame sizes,
// with results checked word by word against an in-bench predictor.
// Depends on src/bgr_pkg.sv and src/bgr_to_nv12_converter.sv.
`timescale 1ns / 100ps

module tb_bgr_to_nv12_converter;
   import bgr_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_PAUSE  = 8;

   // Predicts the luma and chroma words of every accepted pixel and checks the
   // words that come out of the block against them, oldest first.
   class nv12_result_tracker;
      logic [12:0] width_reg;
      logic [12:0] height_reg;
      logic [26:0] line_sums [2048];
      req_type     held;
      int unsigned col_count;
      int unsigned row_count;
      rsp_type     pending_words[$];
      int          mismatch_count;

      function new();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         held = '0;
         col_count = 0;
         row_count = 0;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic idx, logic [12:0] value);
         if (idx == CSR_FRAME_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      // Sizes are forced even, at least 2 and at most the limit.
      function int unsigned effective_size(logic [12:0] value, int unsigned limit);
         int unsigned v;
         v = value & 13'h1FFE;
         if (v < 2) v = 2;
         if (v > limit) v = limit & ~1;
         return v;
      endfunction

      // Round half up at the given binary point, then clamp to 0..255.
      function logic [7:0] round_clamp(longint acc, int unsigned shift);
         longint v;
         v = acc + (longint'(1) << (shift - 1));
         if (v < 0) return 8'd0;
         v = v >>> shift;
         if (v > 255) return 8'd255;
         return v[7:0];
      endfunction

      function void take_pixel(req_type px);
         int unsigned w;
         int unsigned h;
         int unsigned slot;
         logic [8:0]  sum_b;
         logic [8:0]  sum_g;
         logic [8:0]  sum_r;
         longint      v_b;
         longint      v_g;
         longint      v_r;
         rsp_type     word;
         w = effective_size(width_reg, MAX_WIDTH_DEFAULT);
         h = effective_size(height_reg, MAX_HEIGHT_DEFAULT);
         v_b = px.blue;
         v_g = px.green;
         v_r = px.red;

         // Every pixel gives one luma word.
         word = '0;
         word.luma = round_clamp(19595 * v_r + 38470 * v_g + 7471 * v_b, 16);
         word.column = col_count[11:0];
         word.row = row_count[11:0];
         word.last = 1'b1;

         // Even columns are held; odd columns form a horizontal pair. Even rows store
         // the pair sums, odd rows add the stored sums and emit a chroma word.
         if (!col_count[0]) begin
            held = px;
         end else begin
            slot = (col_count >> 1) & 2047;
            sum_b = px.blue + held.blue;
            sum_g = px.green + held.green;
            sum_r = px.red + held.red;
            if (!row_count[0]) begin
               line_sums[slot] = {sum_r, sum_g, sum_b};
            end else begin
               v_b = sum_b + line_sums[slot][8:0];
               v_g = sum_g + line_sums[slot][17:9];
               v_r = sum_r + line_sums[slot][26:18];
               word.last = 1'b0;
               pending_words.push_back(word);
               word = '0;
               word.is_chroma = 1'b1;
               word.cb = round_clamp(-11076 * v_r - 21692 * v_g + 32768 * v_b
                                     + (128 << 18), 18);
               word.cr = round_clamp(32768 * v_r - 27460 * v_g - 5308 * v_b
                                     + (128 << 18), 18);
               word.column = 12'(col_count >> 1);
               word.row = 12'(row_count >> 1);
               word.last = 1'b1;
            end
         end
         pending_words.push_back(word);

         // Column wraps at the width, row at the height; both test with >=.
         col_count++;
         if (col_count >= w) begin
            col_count = 0;
            row_count++;
            if (row_count >= h) row_count = 0;
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            mismatch_count++;
         end
      endfunction

      function void check_word(rsp_type seen);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $error("result word with nothing pending: %p", seen);
            mismatch_count++;
            return;
         end
         want = pending_words.pop_front();
         compare_field("is_chroma", want.is_chroma, seen.is_chroma);
         compare_field("luma", want.luma, seen.luma);
         compare_field("cb", want.cb, seen.cb);
         compare_field("cr", want.cr, seen.cr);
         compare_field("column", want.column, seen.column);
         compare_field("row", want.row, seen.row);
         compare_field("last", want.last, seen.last);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [12:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;

   nv12_result_tracker tracker = new();
   int          send_gap_pct = 0;
   int          ready_stall_pct = 0;
   int          random_sent = 0;
   int          quiet_cycles = 0;
   int unsigned stall_left = 0;

   bgr_to_nv12_converter dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 50;
      endcase
   endfunction

   // Size register values: extremes, odd values and out-of-range values among them.
   function automatic logic [12:0] pick_size(int unsigned small_max);
      case ($urandom_range(0, 19))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'h1FFF;
         4: return 13'd4097;
         5: return 13'd4095;
         default: return 13'($urandom_range(2, small_max));
      endcase
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.blue = pick_channel();
      px.green = pick_channel();
      px.red = pick_channel();
      return px;
   endfunction

   function automatic req_type make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      req_type px;
      px.blue = b;
      px.green = g;
      px.red = r;
      return px;
   endfunction

   // Result side: ready drops for random stretches.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < ready_stall_pct) stall_left = pick_gap();
         end
      end
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_data);
   end

   // Watchdog: ends the run after a long stretch with no word moving either way.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Entered and left at a falling edge; valid stays high between back-to-back words.
   task automatic send_pixel(req_type px);
      int unsigned idle;
      idle = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_data <= px;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_pixel(px);
      @(negedge clock);
   endtask

   // Stop sending, wait for every predicted word, then let the pipeline settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [12:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
      @(negedge clock);
   endtask

   // One random phase: new sizes, new idling mix, then a run of pixels. It ends on an
   // even row, so the next odd row only reads line entries written after the change.
   task automatic run_phase();
      int unsigned n;
      bit          do_width;
      bit          do_height;
      wait_for_drain();
      do_width = $urandom_range(0, 1);
      do_height = !do_width || ($urandom_range(0, 1) == 1);
      if (do_width) write_csr(CSR_FRAME_WIDTH, pick_size(24));
      if (do_height) write_csr(CSR_FRAME_HEIGHT, pick_size(12));
      csr_write <= 1'b0;
      send_gap_pct = pick_pct();
      ready_stall_pct = pick_pct();
      n = $urandom_range(16, 96);
      repeat (n) send_pixel(random_pixel());
      random_sent += n;
      while (tracker.row_count[0]) begin
         send_pixel(random_pixel());
         random_sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A few pixels at the reset size, extremes and alternating bit patterns.
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA));
      send_pixel(make_pixel(8'h55, 8'hAA, 8'h55));

      // Odd width (bit 0 ignored) and a height below the minimum; the column is
      // already past the new width, so the next pixel wraps the row.
      wait_for_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd3);
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      csr_write <= 1'b0;
      send_pixel(make_pixel(8'h12, 8'h34, 8'h56));
      send_pixel(make_pixel(8'h80, 8'h7F, 8'h01));
      send_pixel(make_pixel(8'hFE, 8'h02, 8'hC3));

      // Whole 2x2 blocks: chroma clamped high on blue and on red, then white and black.
      repeat (4) send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
      repeat (4) send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
      repeat (4) send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
      repeat (4) send_pixel(make_pixel(8'h00, 8'h00, 8'h00));

      while (random_sent < RANDOM_ITEMS) run_phase();

      wait_for_drain();
      if (tracker.mismatch_count == 0 && tracker.pending_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== bgr_to_nv12_converter.f =====
src/bgr_pkg.sv
src/bgr_queue.sv
src/bgr_front.sv
src/bgr_back.sv
src/bgr_to_nv12_converter.sv
dv/tb_bgr_to_nv12_converter.sv
